### design/jbhc_pkg.sv
// ----------------------------------------------------------------------------
// jbhc_pkg: shared types and code tables of the block Huffman coder
// Holds the DC and AC luminance code tables and the channel payload types.
// ----------------------------------------------------------------------------
`default_nettype none
package jbhc_pkg;
	localparam int CoefWidth = 12;
	localparam int WordWidth = 27;
	localparam int LenWidth  = 5;
	localparam logic [5:0] LastPos = 6'd63;
	localparam logic [7:0] ZrlSym  = 8'hF0;
	localparam logic [7:0] EobSym  = 8'h00;

	typedef struct packed {
		logic signed [CoefWidth-1:0] coefficient;
	} in_item_t;

	typedef struct packed {
		logic [WordWidth-1:0] code_word;
		logic [LenWidth-1:0]  code_length;
		logic                 last;
	} out_item_t;

	typedef struct packed {
		logic [15:0] code;
		logic [4:0]  len;
	} huff_t;

	// Standard luminance DC table, indexed by category.
	function automatic huff_t dc_huff(input logic [3:0] s);
		huff_t h;
		h = '{code: 16'd0, len: 5'd0};
		case (s)
			4'd0:  h = '{16'h0000, 5'd2};
			4'd1:  h = '{16'h0002, 5'd3};
			4'd2:  h = '{16'h0003, 5'd3};
			4'd3:  h = '{16'h0004, 5'd3};
			4'd4:  h = '{16'h0005, 5'd3};
			4'd5:  h = '{16'h0006, 5'd3};
			4'd6:  h = '{16'h000E, 5'd4};
			4'd7:  h = '{16'h001E, 5'd5};
			4'd8:  h = '{16'h003E, 5'd6};
			4'd9:  h = '{16'h007E, 5'd7};
			4'd10: h = '{16'h00FE, 5'd8};
			4'd11: h = '{16'h01FE, 5'd9};
			default: h = '{16'h0000, 5'd0};
		endcase
		return h;
	endfunction

	// Standard luminance AC table built from its BITS/HUFFVAL lists.
	function automatic huff_t ac_huff(input logic [7:0] rs);
		logic [7:0] vals [162];
		logic [7:0] nbits [16];
		logic [15:0] c;
		int k;
		huff_t h;
		vals = '{8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,
			8'h41,8'h06,8'h13,8'h51,8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,
			8'h91,8'hA1,8'h08,8'h23,8'h42,8'hB1,8'hC1,8'h15,8'h52,8'hD1,8'hF0,
			8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0A,8'h16,8'h17,8'h18,8'h19,
			8'h1A,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2A,8'h34,8'h35,8'h36,8'h37,
			8'h38,8'h39,8'h3A,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,
			8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5A,8'h63,8'h64,8'h65,
			8'h66,8'h67,8'h68,8'h69,8'h6A,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,
			8'h79,8'h7A,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8A,8'h92,
			8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9A,8'hA2,8'hA3,8'hA4,
			8'hA5,8'hA6,8'hA7,8'hA8,8'hA9,8'hAA,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,
			8'hB7,8'hB8,8'hB9,8'hBA,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,
			8'hC9,8'hCA,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,8'hD7,8'hD8,8'hD9,8'hDA,
			8'hE1,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hEA,8'hF1,
			8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'hFA};
		nbits = '{8'd0,8'd2,8'd1,8'd3,8'd3,8'd2,8'd4,8'd3,8'd5,8'd5,8'd4,8'd4,
			8'd0,8'd0,8'd1,8'd125};
		c = 16'd0;
		k = 0;
		h = '{code: 16'd0, len: 5'd0};
		for (int l = 1; l <= 16; l++) begin
			for (int i = 0; i < 125; i++) begin
				if (i < int'(nbits[l-1]) && k < 162) begin
					if (vals[k] == rs) begin
						h.code = c;
						h.len  = 5'(l);
					end
					c = c + 16'd1;
					k = k + 1;
				end
			end
			c = c << 1;
		end
		return h;
	endfunction

	// Magnitude category of a value no wider than 11 bits.
	function automatic logic [3:0] category(input logic [10:0] m);
		logic [3:0] s;
		s = 4'd0;
		for (int i = 0; i < 11; i++) begin
			if (m[i]) s = 4'(i + 1);
		end
		return s;
	endfunction
endpackage
`default_nettype wire

### design/jbhc_stream_if.sv
// ----------------------------------------------------------------------------
// jbhc_stream_if: valid/ready channel
// Carries one payload of type T under a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface jbhc_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/jpeg_block_huffman_coder_unit.sv
// ----------------------------------------------------------------------------
// jpeg_block_huffman_coder_unit: run-length and Huffman coder for one block
// Codes zig-zag ordered quantized coefficients into code words with lengths.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  ---------+-----+--------------------------------------------
//  in_ch    | in  | coefficient (12 bit signed)
//  out_ch   | out | code_word (27), code_length (5), last (1)
//
// One coefficient per cycle enters an input register unless results hold it;
// the coding logic up to the output register is combinational. An item
// with k results holds the input register until all k are taken (up to
// four: three ZRL codes and one AC code); AC zeros before the last position
// give none. Reset clears position, run count and both valid flags. A stall
// on the output holds the output register and a result-giving item behind it.
`default_nettype none
module jpeg_block_huffman_coder_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	jbhc_stream_if.sink   in_ch,
	jbhc_stream_if.source out_ch
);
	import jbhc_pkg::*;

	logic                        vld_s1;
	logic signed [CoefWidth-1:0] coef_s1;
	logic [5:0]                  pos_q;
	logic [5:0]                  run_q;
	logic                        vld_s2;
	out_item_t                   res_s2;

	logic       out_free;
	logic       take_res;
	logic       done_item;
	logic       has_res;
	logic       is_zrl;
	logic [5:0] run_next;
	logic [5:0] pos_next;
	out_item_t  res_d;

	logic [10:0] mag;
	logic [3:0]  cat;
	logic [10:0] extra;
	logic        is_dc;
	logic        is_zero;
	huff_t       hc;
	logic [4:0]  cat_len;
	logic signed [CoefWidth-1:0] sat;

	assign out_free = !vld_s2 || out_ch.ready;

	// Saturate: DC to +-2047, AC to +-1023.
	always_comb begin
		is_dc   = (pos_q == 6'd0);
		is_zero = (coef_s1 == '0);
		sat     = coef_s1;
		if (is_dc) begin
			if (coef_s1 == -12'sd2048) sat = -12'sd2047;
		end else begin
			if (coef_s1 > 12'sd1023)  sat = 12'sd1023;
			if (coef_s1 < -12'sd1023) sat = -12'sd1023;
		end
		mag   = sat[CoefWidth-1] ? 11'(-sat) : sat[10:0];
		cat   = category(mag);
		extra = sat[CoefWidth-1] ? 11'(sat - 12'sd1) : sat[10:0];
		extra = extra & 11'((12'd1 << cat) - 12'd1);
	end

	// Pick the code for the current step of the item in the input register.
	always_comb begin
		is_zrl   = 1'b0;
		has_res  = 1'b1;
		run_next = 6'd0;
		pos_next = (pos_q == LastPos) ? 6'd0 : pos_q + 6'd1;
		cat_len  = 5'(cat);
		hc       = dc_huff(cat);
		if (is_dc) begin
			hc = dc_huff(cat);
		end else if (is_zero) begin
			cat_len = 5'd0;
			hc      = ac_huff(EobSym);
			has_res = (pos_q == LastPos);
			run_next = (pos_q == LastPos) ? 6'd0 : run_q + 6'd1;
		end else if (run_q > 6'd15) begin
			is_zrl  = 1'b1;
			cat_len = 5'd0;
			hc      = ac_huff(ZrlSym);
		end else begin
			hc = ac_huff({run_q[3:0], cat});
		end
		res_d.code_word   = 27'({11'd0, hc.code} << cat_len)
			| (cat_len == 5'd0 ? 27'd0 : 27'(extra));
		res_d.code_length = hc.len + cat_len;
		res_d.last        = !is_zrl;
	end

	assign take_res  = vld_s1 && has_res && out_free;
	assign done_item = vld_s1 && (has_res ? (out_free && !is_zrl) : 1'b1);
	assign in_ch.ready = !vld_s1 || done_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			pos_q  <= 6'd0;
			run_q  <= 6'd0;
		end else begin
			// Drain ZRL codes one per cycle while the output takes them; subtract 16 from the run.
			if (take_res && is_zrl) run_q <= run_q - 6'd16;
			if (done_item) begin
				pos_q <= pos_next;
				run_q <= run_next;
			end
			if (in_ch.ready) vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) coef_s1 <= in_ch.data.coefficient;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (out_free) begin
			vld_s2 <= take_res;
		end
	end

	always_ff @(posedge clk) begin
		if (take_res) res_s2 <= res_d;
	end

	assign out_ch.valid = vld_s2;
	assign out_ch.data  = res_s2;

	a_run_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= 6'd62) else $error("zero run past block end");
	a_zrl_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		take_res && is_zrl |=> vld_s2 && !res_s2.last) else $error("ZRL marked last");
	a_block_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		done_item && pos_q == LastPos |=> pos_q == 6'd0 && run_q == 6'd0)
		else $error("block did not wrap");
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> res_s2.code_length != 5'd0) else $error("empty code");
endmodule
`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the block Huffman coder
// Streams coefficient blocks into the coder, predicts the DC, AC, ZRL and EOB
// code words of every transfer, and checks each output transfer against them.
// ----------------------------------------------------------------------------
`default_nettype none

// Expected code words in arrival order, plus the running block state.
class huffman_scoreboard;
	jbhc_pkg::out_item_t pending_codes[$];
	bit [5:0] block_pos;
	bit [5:0] run_count;
	int       fail_count;
	int       checked_count;

	function new();
		block_pos = 6'd0;
		run_count = 6'd0;
		fail_count = 0;
		checked_count = 0;
	endfunction

	// Category of a magnitude, counted bit by bit.
	function automatic int magnitude_bits(input int m);
		int s;
		s = 0;
		while (m != 0) begin
			s++;
			m = m >>> 1;
		end
		return s;
	endfunction

	// Code of a category in the standard luminance DC table.
	function automatic void dc_entry(input int s, output int code, output int len);
		if (s == 0) begin
			code = 0;
			len = 2;
		end else if (s <= 5) begin
			code = s + 1;
			len = 3;
		end else begin
			len = s - 2;
			code = (1 << len) - 2;
		end
	endfunction

	// Code of a run/size symbol in the standard luminance AC table.
	function automatic void ac_entry(input bit [7:0] rs, output int code,
			output int len);
		byte unsigned vals[162];
		byte unsigned nbits[16];
		int c, k;
		vals = '{8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,
			8'h41,8'h06,8'h13,8'h51,8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,
			8'h91,8'hA1,8'h08,8'h23,8'h42,8'hB1,8'hC1,8'h15,8'h52,8'hD1,8'hF0,
			8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0A,8'h16,8'h17,8'h18,8'h19,
			8'h1A,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2A,8'h34,8'h35,8'h36,8'h37,
			8'h38,8'h39,8'h3A,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,
			8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5A,8'h63,8'h64,8'h65,
			8'h66,8'h67,8'h68,8'h69,8'h6A,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,
			8'h79,8'h7A,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8A,8'h92,
			8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9A,8'hA2,8'hA3,8'hA4,
			8'hA5,8'hA6,8'hA7,8'hA8,8'hA9,8'hAA,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,
			8'hB7,8'hB8,8'hB9,8'hBA,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,
			8'hC9,8'hCA,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,8'hD7,8'hD8,8'hD9,8'hDA,
			8'hE1,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hEA,8'hF1,
			8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'hFA};
		nbits = '{0, 2, 1, 3, 3, 2, 4, 3, 5, 5, 4, 4, 0, 0, 1, 125};
		c = 0;
		k = 0;
		code = 0;
		len = 0;
		for (int l = 1; l <= 16; l++) begin
			for (int i = 0; i < nbits[l-1] && k < 162; i++) begin
				if (vals[k] == rs) begin
					code = c;
					len = l;
				end
				c++;
				k++;
			end
			c = c << 1;
		end
	endfunction

	// Queue one code word: Huffman code, then s extra bits of the value.
	function automatic void push_code(input int code, input int len, input int v,
			input int s);
		jbhc_pkg::out_item_t item;
		int extra;
		extra = (v < 0) ? v - 1 : v;
		extra = extra & ((1 << s) - 1);
		item.code_word = 27'((code << s) | extra);
		item.code_length = 5'(len + s);
		item.last = 1'b0;
		pending_codes.push_back(item);
	endfunction

	// Note one accepted coefficient and queue the codes it gives.
	function automatic void note_coefficient(input logic signed [11:0] coef);
		int v, s, code, len, first;
		v = coef;
		first = pending_codes.size();
		if (block_pos == 6'd0) begin
			if (v < -2047) v = -2047;
			s = magnitude_bits(v < 0 ? -v : v);
			dc_entry(s, code, len);
			push_code(code, len, v, s);
			run_count = 6'd0;
			block_pos = 6'd1;
		end else begin
			if (v == 0) begin
				if (block_pos == jbhc_pkg::LastPos) begin
					ac_entry(jbhc_pkg::EobSym, code, len);
					push_code(code, len, 0, 0);
				end else begin
					run_count = run_count + 6'd1;
				end
			end else begin
				if (v > 1023) v = 1023;
				if (v < -1023) v = -1023;
				// Emit a ZRL for each full run of sixteen zeros, three at most.
				while (run_count > 6'd15 && pending_codes.size() - first < 3) begin
					ac_entry(jbhc_pkg::ZrlSym, code, len);
					push_code(code, len, 0, 0);
					run_count = run_count - 6'd16;
				end
				s = magnitude_bits(v < 0 ? -v : v);
				ac_entry({run_count[3:0], 4'(s)}, code, len);
				push_code(code, len, v, s);
				run_count = 6'd0;
			end
			if (block_pos == jbhc_pkg::LastPos) begin
				block_pos = 6'd0;
				run_count = 6'd0;
			end else begin
				block_pos = block_pos + 6'd1;
			end
		end
		if (pending_codes.size() > first)
			pending_codes[pending_codes.size()-1].last = 1'b1;
	endfunction

	// Compare one output transfer with the oldest expected code word.
	function automatic void check_code(input jbhc_pkg::out_item_t got);
		jbhc_pkg::out_item_t want;
		if (pending_codes.size() == 0) begin
			$error("unexpected code word %h len %0d", got.code_word, got.code_length);
			fail_count++;
			return;
		end
		want = pending_codes.pop_front();
		checked_count++;
		if (got.code_word !== want.code_word) begin
			$error("code_word: expected %h actual %h", want.code_word, got.code_word);
			fail_count++;
		end
		if (got.code_length !== want.code_length) begin
			$error("code_length: expected %0d actual %0d", want.code_length,
				got.code_length);
			fail_count++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %b actual %b", want.last, got.last);
			fail_count++;
		end
	endfunction
endclass

module tb_top;
	import jbhc_pkg::*;

	localparam int CycleLimit = 200000;

	logic clk;
	logic arst_n;
	int   cycle_count;
	int   sent_count;
	bit   idle_enable;

	jbhc_stream_if #(.T(in_item_t))  in_ch ();
	jbhc_stream_if #(.T(out_item_t)) out_ch ();

	huffman_scoreboard coded_words = new();

	jpeg_block_huffman_coder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold reset low at the start, then release it for good.
	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Drive ready with random stalls while idling is enabled.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= !(idle_enable && $urandom_range(99) < 31);
		end
	end

	// Check every output transfer against the expected code words.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			coded_words.check_code(out_ch.data);
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("cycle limit reached with %0d code words pending",
				coded_words.pending_codes.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Send one coefficient: hold valid until the transfer, with random gaps.
	task automatic send_coef(input int v);
		while (idle_enable && $urandom_range(99) < 31) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data.coefficient <= 12'(v);
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		coded_words.note_coefficient(12'(v));
		sent_count++;
	endtask

	// Drop valid and advance until every expected code word has arrived.
	task automatic drain_codes();
		in_ch.valid <= 1'b0;
		while (coded_words.pending_codes.size() != 0) @(posedge clk);
	endtask

	// Random AC value: mostly small, sometimes large, beyond 1023 at times.
	function automatic int random_ac();
		int r;
		r = $urandom_range(99);
		if (r < 60) return $urandom_range(1, 15) * ($urandom_range(1) ? 1 : -1);
		if (r < 90) return $urandom_range(16, 1023) * ($urandom_range(1) ? 1 : -1);
		return int'($signed(12'($urandom)));
	endfunction

	// Send a well-formed block whose zero runs reach the given length.
	task automatic send_block(input int max_run, input bit eob_zero);
		int pos, run;
		send_coef(int'($signed(12'($urandom))));
		pos = 1;
		while (pos < 64) begin
			run = $urandom_range(max_run);
			for (int i = 0; i < run && pos < 63; i++) begin
				send_coef(0);
				pos++;
			end
			if (pos == 63) send_coef(eob_zero ? 0 : random_ac());
			else send_coef(random_ac());
			pos++;
		end
	endtask

	initial begin
		int dc_list[8];
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cycle_count = 0;
		sent_count = 0;
		idle_enable = 1'b0;
		dc_list = '{2047, -2047, 0, 1, -1, -2048, 1024, -1024};
		@(posedge arst_n);
		@(posedge clk);

		// Directed part: DC extremes on one-coefficient blocks would need 64
		// items each, so pack them into blocks with long zero runs instead.
		// Block 1: DC -2048 (saturated), AC beyond 1023 both signs, AC -1,
		// a run of 47 zeros (two ZRL codes), then EOB at the last position.
		send_coef(-2048);
		send_coef(2047);
		send_coef(-2048);
		send_coef(1);
		send_coef(-1);
		for (int i = 0; i < 47; i++) send_coef(0);
		send_coef(1023);
		for (int i = 53; i < 63; i++) send_coef(0);
		send_coef(0);
		// Block 2: DC of zero, a run of 62 zeros ending in a nonzero last.
		send_coef(0);
		for (int i = 1; i < 63; i++) send_coef(0);
		send_coef(-1024);
		// Pause until every code word is out.
		drain_codes();

		// Random part, first without idling, then with it.
		foreach (dc_list[i]) begin
			if (i == 1) idle_enable = 1'b1;
			send_coef(dc_list[i]);
			for (int p = 1; p < 64; p++)
				send_coef(($urandom_range(99) < 60) ? 0 : random_ac());
			if (sent_count >= 256) break;
		end
		send_block(20, 1'b1);
		send_block(40, 1'b0);
		drain_codes();

		repeat (20) @(posedge clk);
		$display("sent %0d coefficients, checked %0d code words incl. ZRL, EOB",
			sent_count, coded_words.checked_count);
		$display("DC and AC extremes, saturation and long zero runs were covered");
		if (coded_words.fail_count == 0 && coded_words.pending_codes.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

`default_nettype wire

### jpeg_block_huffman_coder_unit.f
design/jbhc_pkg.sv
design/jbhc_stream_if.sv
design/jpeg_block_huffman_coder_unit.sv
test/tb_top.sv
